### sv/vt_pkg.sv
`default_nettype none
package vt_pkg;

    localparam int DATA_W        = 32;
    localparam int REG_W         = 64;
    localparam int NUM_REGS      = 8;
    localparam int IDX_W         = 3;
    localparam int FRAC_BITS_DEF = 16;
    // quotient bits kept by the divider: one above the output width for clip detection
    localparam int QW            = DATA_W + 1;
    // product stage, column sum stage
    localparam int COL_LAT       = 2;
    // magnitude stage, numerator align stage, one stage per quotient bit, result stage
    localparam int LANE_LAT      = QW + 3;
    localparam int PIPE_LAT      = COL_LAT + LANE_LAT;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROW0_01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_23 = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_01 = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_23 = 3'd7;

    localparam logic FUNC_POINT = 1'b0;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              clip;
        logic              wz;
    } lane_out_t;

    // width of a floored column sum including translation
    function automatic int col_w(input int frac);
        return 2 * DATA_W + 3 - frac;
    endfunction

endpackage
`default_nettype wire

### sv/vt_col.sv
`default_nettype none
module vt_col #(
    parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      en,
    input  wire logic                                      func,
    input  wire logic signed [vt_pkg::DATA_W-1:0]          in_x,
    input  wire logic signed [vt_pkg::DATA_W-1:0]          in_y,
    input  wire logic signed [vt_pkg::DATA_W-1:0]          in_z,
    input  wire vt_pkg::matrix_t                           matrix,
    output logic                                           point,
    output logic signed [vt_pkg::col_w(FRAC_BITS)-1:0]     col [0:3]
);
    import vt_pkg::*;

    localparam int CW = col_w(FRAC_BITS);
    localparam int PW = 2 * DATA_W;
    localparam int SW = PW + 2;

    logic signed [DATA_W-1:0] elem [0:3][0:3];
    logic signed [DATA_W-1:0] vin  [0:2];
    logic signed [PW-1:0]     p_reg  [0:3][0:2];
    logic signed [PW-1:0]     p_next [0:3][0:2];
    logic                     func_reg;
    logic signed [CW-1:0]     col_reg  [0:3];
    logic signed [CW-1:0]     col_next [0:3];
    logic                     point_reg;
    logic signed [SW-1:0]     sum      [0:3];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                elem[r][c] = matrix[2 * r + c / 2][(c % 2) * DATA_W +: DATA_W];
            end
        end
    end

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;

    // exact element products
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                p_next[c][r] = PW'(vin[r]) * PW'(elem[r][c]);
            end
        end
    end

    // exact sum, floor to fixed point, translation in point mode
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = SW'(p_reg[c][0]) + SW'(p_reg[c][1]) + SW'(p_reg[c][2]);
            col_next[c] = CW'(sum[c] >>> FRAC_BITS);
            if (func_reg == FUNC_POINT)
            begin
                col_next[c] = col_next[c] + CW'(elem[3][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            func_reg  <= func;
            col_reg   <= col_next;
            point_reg <= (func_reg == FUNC_POINT);
        end
    end

    assign col   = col_reg;
    assign point = point_reg;

endmodule
`default_nettype wire

### sv/vt_lane.sv
`default_nettype none
module vt_lane #(
    parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic                                  point,
    input  wire logic signed [vt_pkg::col_w(FRAC_BITS)-1:0] num,
    input  wire logic signed [vt_pkg::col_w(FRAC_BITS)-1:0] den,
    output vt_pkg::lane_out_t                          res
);
    import vt_pkg::*;

    localparam int CW = col_w(FRAC_BITS);
    localparam int RW = CW + QW;
    localparam logic signed [CW-1:0] MAXV = CW'(64'sh7FFFFFFF);
    localparam logic signed [CW-1:0] MINV = -MAXV - CW'(1);

    typedef struct packed {
        logic              ovf;
        logic              neg;
        logic              wz;
        logic              point;
        logic              dclip;
        logic [DATA_W-1:0] dsat;
        logic [CW-1:0]     ad;
    } side_t;

    side_t          pre_reg, pre_next;
    logic [CW-1:0]  an_reg, an_next;
    side_t          side_reg [0:QW];
    logic [RW-1:0]  rem_reg  [0:QW-1];
    logic [QW-1:0]  q_reg    [0:QW];
    side_t          side0_next;
    logic [RW-1:0]  num_al;
    lane_out_t      res_reg, res_next;
    side_t          fin;
    logic [QW-1:0]  qf;
    logic           pclip;
    logic [DATA_W-1:0] pval;

    // signs, magnitudes, direction-mode saturation
    always_comb
    begin
        pre_next.neg   = num[CW-1] ^ den[CW-1];
        pre_next.wz    = (den == '0);
        pre_next.point = point;
        pre_next.ovf   = 1'b0;
        pre_next.ad    = den[CW-1] ? CW'(-den) : CW'(den);
        an_next        = num[CW-1] ? CW'(-num) : CW'(num);
        if (num > MAXV)
        begin
            pre_next.dclip = 1'b1;
            pre_next.dsat  = DATA_W'(MAXV);
        end
        else if (num < MINV)
        begin
            pre_next.dclip = 1'b1;
            pre_next.dsat  = DATA_W'(MINV);
        end
        else
        begin
            pre_next.dclip = 1'b0;
            pre_next.dsat  = DATA_W'(num);
        end
    end

    // align numerator, flag quotients beyond the kept width
    always_comb
    begin
        num_al         = RW'(an_reg) << FRAC_BITS;
        side0_next     = pre_reg;
        side0_next.ovf = (num_al >= (RW'(pre_reg.ad) << QW));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg     <= pre_next;
            an_reg      <= an_next;
            side_reg[0] <= side0_next;
            rem_reg[0]  <= num_al;
            q_reg[0]    <= '0;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar g = 0; g < QW; g++)
    begin : g_step
        localparam int BIT = QW - 1 - g;
        logic [RW-1:0] dsh;
        logic          ge;
        logic [QW-1:0] q_next;

        assign dsh = RW'(side_reg[g].ad) << BIT;
        assign ge  = (rem_reg[g] >= dsh);

        always_comb
        begin
            q_next      = q_reg[g];
            q_next[BIT] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g+1] <= side_reg[g];
                q_reg[g+1]    <= q_next;
            end
        end

        if (g < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= ge ? (rem_reg[g] - dsh) : rem_reg[g];
                end
            end
        end
    end

    // sign, saturation and mode select
    always_comb
    begin
        fin = side_reg[QW];
        qf  = q_reg[QW];
        if (fin.neg)
        begin
            pclip = fin.ovf || (qf > (QW'(1) << (DATA_W - 1)));
            pval  = pclip ? (DATA_W'(1) << (DATA_W - 1)) : DATA_W'(-qf);
        end
        else
        begin
            pclip = fin.ovf || (qf[QW-1:DATA_W-1] != '0);
            pval  = pclip ? ~(DATA_W'(1) << (DATA_W - 1)) : qf[DATA_W-1:0];
        end

        if (!fin.point)
        begin
            res_next.val  = fin.dsat;
            res_next.clip = fin.dclip;
            res_next.wz   = 1'b0;
        end
        else if (fin.wz)
        begin
            res_next.val  = '0;
            res_next.clip = 1'b0;
            res_next.wz   = 1'b1;
        end
        else
        begin
            res_next.val  = pval;
            res_next.clip = pclip;
            res_next.wz   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### sv/vertex_transform_4x4.sv
// vertex transform 4x4: throughput one beat per cycle unless the output is stalled;
// the 33-stage restoring divider and the two-stage product/sum front end
// are fully pipelined
// a stalled output freezes the whole pipeline, no beat is lost or repeated
// reset (async, active low) clears all valid bits and loads the identity matrix
`default_nettype none
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              func,
    input  wire logic signed [vt_pkg::DATA_W-1:0]  in_x,
    input  wire logic signed [vt_pkg::DATA_W-1:0]  in_y,
    input  wire logic signed [vt_pkg::DATA_W-1:0]  in_z,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [vt_pkg::DATA_W-1:0]       out_x,
    output logic signed [vt_pkg::DATA_W-1:0]       out_y,
    output logic signed [vt_pkg::DATA_W-1:0]       out_z,
    output logic                                   w_zero,
    output logic                                   saturated,
    // configuration write port
    input  wire logic                              wr_en,
    input  wire logic [vt_pkg::IDX_W-1:0]          wr_index,
    input  wire logic [vt_pkg::REG_W-1:0]          wr_data
);
    import vt_pkg::*;

    // identity matrix in register layout
    function automatic matrix_t ident_matrix(input int frac);
        matrix_t          m;
        logic [REG_W-1:0] one;
        one = REG_W'(1) << frac;
        m = '0;
        m[REG_ROW0_01] = one;
        m[REG_ROW1_01] = one << DATA_W;
        m[REG_ROW2_23] = one;
        m[REG_ROW3_23] = one << DATA_W;
        return m;
    endfunction

    localparam int CW = col_w(FRAC_BITS);
    localparam matrix_t MAT_RESET = ident_matrix(FRAC_BITS);

    matrix_t               mat_reg;
    logic [PIPE_LAT-1:0]   vld_reg;
    logic                  en;
    logic                  point;
    logic signed [CW-1:0]  col [0:3];
    lane_out_t             lane_res [0:2];

    // global advance: everything moves unless the output beat is held
    assign en       = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall = !en;

    // matrix registers, reset to identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= MAT_RESET;
        end
        else if (wr_en)
        begin
            mat_reg[wr_index] <= wr_data;
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    // products and floored column sums, w in column 3
    vt_col #(
        .FRAC_BITS (FRAC_BITS)
    ) u_col (
        .clk    (clk),
        .en     (en),
        .func   (func),
        .in_x   (in_x),
        .in_y   (in_y),
        .in_z   (in_z),
        .matrix (mat_reg),
        .point  (point),
        .col    (col)
    );

    // one divide lane per output component, each also handles saturation
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .point (point),
            .num   (col[c]),
            .den   (col[3]),
            .res   (lane_res[c])
        );
    end

    assign out_valid = vld_reg[PIPE_LAT-1];
    assign out_x     = lane_res[0].val;
    assign out_y     = lane_res[1].val;
    assign out_z     = lane_res[2].val;
    // all lanes see the same w, any one gives the flag
    assign w_zero    = lane_res[0].wz & lane_res[1].wz & lane_res[2].wz;
    assign saturated = lane_res[0].clip | lane_res[1].clip | lane_res[2].clip;

endmodule
`default_nettype wire
